// ----- src/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and constants of the click stroke line painter.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  // Default canvas geometry
  localparam int unsigned DEF_CANVAS_WIDTH  = 256;
  localparam int unsigned DEF_CANVAS_HEIGHT = 128;

  // Window layout in screen coordinates, relative to the origin registers
  localparam int unsigned CANVAS_LEFT  = 8;
  localparam int unsigned CANVAS_TOP   = 32;
  localparam int unsigned PALETTE_GAP  = 4;
  localparam int unsigned PALETTE_ROWS = 12;

  // Palette band right edges, in canvas x
  localparam int unsigned BAND_BLACK = 20;
  localparam int unsigned BAND_RED   = 44;
  localparam int unsigned BAND_BLUE  = 68;
  localparam int unsigned BAND_GREEN = 92;

  localparam logic [31:0] COLOR_BLACK = 32'hFF00_0000;
  localparam logic [31:0] COLOR_RED   = 32'hFFE7_4C3C;
  localparam logic [31:0] COLOR_BLUE  = 32'hFF34_98DB;
  localparam logic [31:0] COLOR_GREEN = 32'hFF2E_CC71;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;

  typedef enum logic [1:0] {
    ACT_CLICK = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_BRUSH = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_IGNORED = 3'd0,
    STAT_PALETTE = 3'd1,
    STAT_PAINTED = 3'd2,
    STAT_READ    = 3'd3,
    STAT_CLEARED = 3'd4,
    STAT_BRUSH   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CLK_NONE,
    CLK_PALETTE,
    CLK_PAINT
  } click_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LINE,
    FSM_CLEAR,
    FSM_READ,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    click_e      kind;
    logic [31:0] brush;
  } click_t;

  typedef struct packed {
    action_e     action;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] color;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] pixel_color;
    logic [31:0] brush_color;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/csp_chan_if.sv -----
// ----------------------------------------------------------------------------
// csp_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface csp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/click_stroke_line_painter_core.sv -----
// ----------------------------------------------------------------------------
// click_stroke_line_painter_core
// Canvas painter: palette picks, thick-point Bresenham strokes, clear, read, set brush.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one action per transaction (click, read pixel, clear canvas,
//   set brush); out_o returns exactly one result per accepted transaction, in
//   order. cfg_we_i/cfg_idx_i/cfg_data_i write the window origin registers;
//   write them only while the block is idle.
// Throughput: one item at a time; in_i.ready is high only when the
//   sequencer is idle. Brush, palette and ignored items go from the idle
//   state through the done state to the output register, a read also
//   passes the read state (registered canvas RAM read), a paint makes three
//   clipped pixel writes per line point through the single RAM write port,
//   a clear writes the whole canvas at one RAM word per cycle.
// Reset: brush goes black, the stroke point is forgotten and the origins go
//   to zero. The canvas RAM is not initialized; read a pixel only after a
//   clear or a paint has written it.
// Stall: the result sits in the output register until out_o.ready; the next
//   item may be taken meanwhile and waits in the done state for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module click_stroke_line_painter_core import csp_pkg::*; #(
  parameter int unsigned CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int unsigned CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  csp_chan_if.sink                  in_i,
  csp_chan_if.source                out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned XW    = $clog2(CANVAS_WIDTH);
  localparam int unsigned YW    = $clog2(CANVAS_HEIGHT);
  localparam int unsigned DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  fsm_e          state_q, state_d;
  logic [11:0]   origin_x_q, origin_y_q;
  logic [31:0]   brush_q, brush_d;
  logic          prev_valid_q, prev_valid_d;
  logic [XW-1:0] prev_x_q, prev_x_d;
  logic [YW-1:0] prev_y_q, prev_y_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   clr_color_q, clr_color_d;
  out_item_t     res_q, res_d;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  in_item_t      item;
  logic          in_fire;
  click_t        click;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic          rd_in_range;

  logic          line_start, line_busy, line_wr_en;
  logic [AW-1:0] line_wr_addr;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign item    = in_i.data;
  assign in_i.ready = (state_q == FSM_IDLE);
  assign in_fire = in_i.valid && in_i.ready;

  // Click geometry against the current window origin
  csp_click_dec #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_click_dec (
    .origin_x_i(origin_x_q),
    .origin_y_i(origin_y_q),
    .pos_x_i   (item.pos_x),
    .pos_y_i   (item.pos_y),
    .click_o   (click),
    .cx_o      (cx),
    .cy_o      (cy)
  );

  // Stroke engine; a first click draws a zero-length line, i.e. one thick point
  csp_line #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (line_start),
    .x0_i     (prev_valid_q ? prev_x_q : cx),
    .y0_i     (prev_valid_q ? prev_y_q : cy),
    .x1_i     (cx),
    .y1_i     (cy),
    .busy_o   (line_busy),
    .wr_en_o  (line_wr_en),
    .wr_addr_o(line_wr_addr)
  );

  // Canvas storage
  csp_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_in_range = (item.pos_x < 12'(CANVAS_WIDTH)) && (item.pos_y < 12'(CANVAS_HEIGHT));
  assign ram_raddr   = AW'(item.pos_y[YW-1:0]) * AW'(CANVAS_WIDTH) + AW'(item.pos_x[XW-1:0]);
  assign ram_re      = in_fire && (item.action == ACT_READ) && rd_in_range;

  // Write port: clear sweep owns it in the clear state, stroke engine otherwise
  assign ram_we    = (state_q == FSM_CLEAR) || line_wr_en;
  assign ram_waddr = (state_q == FSM_CLEAR) ? clr_q : line_wr_addr;
  assign ram_wdata = (state_q == FSM_CLEAR) ? clr_color_q : brush_q;

  always_comb begin
    state_d      = state_q;
    brush_d      = brush_q;
    prev_valid_d = prev_valid_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    clr_d        = clr_q;
    clr_color_d  = clr_color_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    line_start   = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          res_d.status      = STAT_IGNORED;
          res_d.pixel_color = '0;
          state_d           = FSM_DONE;
          unique case (item.action)
            ACT_CLICK: begin
              if (click.kind == CLK_PALETTE) begin
                brush_d      = click.brush;
                res_d.status = STAT_PALETTE;
              end else if (click.kind == CLK_PAINT) begin
                line_start   = 1'b1;
                prev_valid_d = 1'b1;
                prev_x_d     = cx;
                prev_y_d     = cy;
                res_d.status = STAT_PAINTED;
                state_d      = FSM_LINE;
              end
            end
            ACT_READ: begin
              if (rd_in_range) begin
                res_d.status = STAT_READ;
                state_d      = FSM_READ;
              end
            end
            ACT_CLEAR: begin
              clr_d        = '0;
              clr_color_d  = item.color;
              res_d.status = STAT_CLEARED;
              state_d      = FSM_CLEAR;
            end
            ACT_BRUSH: begin
              brush_d      = item.color;
              res_d.status = STAT_BRUSH;
            end
            default: ;
          endcase
          res_d.brush_color = brush_d;
        end
      end
      FSM_LINE: begin
        // the last pixel write leaves the engine in the cycle busy drops
        if (!line_busy) begin
          state_d = FSM_DONE;
        end
      end
      FSM_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = FSM_DONE;
        end
      end
      FSM_READ: begin
        res_d.pixel_color = ram_rdata;
        state_d           = FSM_DONE;
      end
      FSM_DONE: begin
        // hold the result until the output slot frees up
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      brush_q      <= COLOR_BLACK;
      prev_valid_q <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
    end else begin
      state_q      <= state_d;
      brush_q      <= brush_d;
      prev_valid_q <= prev_valid_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
          CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clr_color_q <= clr_color_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ----- src/csp_ram.sv -----
// ----------------------------------------------------------------------------
// csp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/csp_click_dec.sv -----
// ----------------------------------------------------------------------------
// csp_click_dec
// Map a screen click to a palette pick, a canvas point or nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_click_dec import csp_pkg::*; #(
  parameter int unsigned CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int unsigned CANVAS_HEIGHT = DEF_CANVAS_HEIGHT,
  localparam int unsigned XW = $clog2(CANVAS_WIDTH),
  localparam int unsigned YW = $clog2(CANVAS_HEIGHT)
) (
  input  wire logic [11:0]   origin_x_i,
  input  wire logic [11:0]   origin_y_i,
  input  wire logic [11:0]   pos_x_i,
  input  wire logic [11:0]   pos_y_i,
  output click_t             click_o,
  output logic      [XW-1:0] cx_o,
  output logic      [YW-1:0] cy_o
);

  localparam int unsigned SW = 15;
  localparam logic signed [SW-1:0] LEFT_S  = SW'(CANVAS_LEFT);
  localparam logic signed [SW-1:0] TOP_S   = SW'(CANVAS_TOP);
  localparam logic signed [SW-1:0] PROW_S  = SW'(CANVAS_TOP + CANVAS_HEIGHT + PALETTE_GAP);
  localparam logic signed [SW-1:0] ROWS_S  = SW'(PALETTE_ROWS);
  localparam logic signed [SW-1:0] W_S     = SW'(CANVAS_WIDTH);
  localparam logic signed [SW-1:0] H_S     = SW'(CANVAS_HEIGHT);
  localparam logic signed [SW-1:0] B0_S    = SW'(BAND_BLACK);
  localparam logic signed [SW-1:0] B1_S    = SW'(BAND_RED);
  localparam logic signed [SW-1:0] B2_S    = SW'(BAND_BLUE);
  localparam logic signed [SW-1:0] B3_S    = SW'(BAND_GREEN);

  logic signed [SW-1:0] sx, sy, ox, oy, cx, cy, prow;
  logic                 pal_row, in_canvas;

  assign sx   = $signed({3'b000, pos_x_i});
  assign sy   = $signed({3'b000, pos_y_i});
  assign ox   = $signed({3'b000, origin_x_i});
  assign oy   = $signed({3'b000, origin_y_i});
  assign cx   = sx - ox - LEFT_S;
  assign cy   = sy - oy - TOP_S;
  assign prow = oy + PROW_S;

  assign pal_row   = (sy >= prow) && (sy < prow + ROWS_S);
  assign in_canvas = (cx >= 0) && (cy >= 0) && (cx < W_S) && (cy < H_S);

  assign cx_o = cx[XW-1:0];
  assign cy_o = cy[YW-1:0];

  always_comb begin
    click_o.kind  = CLK_NONE;
    click_o.brush = COLOR_BLACK;
    if (pal_row) begin
      // palette strip wins over the canvas; a click left of the strip picks black
      click_o.kind = CLK_PALETTE;
      if (cx < B0_S) begin
        click_o.brush = COLOR_BLACK;
      end else if (cx < B1_S) begin
        click_o.brush = COLOR_RED;
      end else if (cx < B2_S) begin
        click_o.brush = COLOR_BLUE;
      end else if (cx < B3_S) begin
        click_o.brush = COLOR_GREEN;
      end else begin
        click_o.kind = CLK_NONE;
      end
    end else if (in_canvas) begin
      click_o.kind = CLK_PAINT;
    end
  end

endmodule

`default_nettype wire

// ----- src/csp_line.sv -----
// ----------------------------------------------------------------------------
// csp_line
// Bresenham stepper that emits three clipped pixel writes per line point.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_line import csp_pkg::*; #(
  parameter int unsigned CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int unsigned CANVAS_HEIGHT = DEF_CANVAS_HEIGHT,
  localparam int unsigned XW = $clog2(CANVAS_WIDTH),
  localparam int unsigned YW = $clog2(CANVAS_HEIGHT),
  localparam int unsigned AW = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [XW-1:0] x0_i,
  input  wire logic [YW-1:0] y0_i,
  input  wire logic [XW-1:0] x1_i,
  input  wire logic [YW-1:0] y1_i,
  output logic               busy_o,
  output logic               wr_en_o,
  output logic      [AW-1:0] wr_addr_o
);

  localparam int unsigned EW = ((XW > YW) ? XW : YW) + 3;
  localparam logic [1:0] PH_CENTER = 2'd0;
  localparam logic [1:0] PH_RIGHT  = 2'd1;
  localparam logic [1:0] PH_BELOW  = 2'd2;

  logic                 busy_q, busy_d;
  logic [1:0]           phase_q, phase_d;
  logic [XW-1:0]        xa_q, xa_d, xb_q, xb_d;
  logic [YW-1:0]        ya_q, ya_d, yb_q, yb_d;
  logic signed [EW-1:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic                 stx_neg_q, stx_neg_d, sty_neg_q, sty_neg_d;
  logic                 wr_en_q, wr_en_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;

  logic signed [EW-1:0] x0s, x1s, y0s, y1s, dx_s, dy_s, twice;
  logic [XW:0]          px;
  logic [YW:0]          py;

  assign x0s = $signed({{(EW-XW){1'b0}}, x0_i});
  assign x1s = $signed({{(EW-XW){1'b0}}, x1_i});
  assign y0s = $signed({{(EW-YW){1'b0}}, y0_i});
  assign y1s = $signed({{(EW-YW){1'b0}}, y1_i});
  assign dx_s = (x1s > x0s) ? (x1s - x0s) : (x0s - x1s);
  assign dy_s = (y1s > y0s) ? (y1s - y0s) : (y0s - y1s);

  assign px    = {1'b0, xa_q} + {{XW{1'b0}}, (phase_q == PH_RIGHT)};
  assign py    = {1'b0, ya_q} + {{YW{1'b0}}, (phase_q == PH_BELOW)};
  assign twice = err_q <<< 1;

  always_comb begin
    busy_d    = busy_q;
    phase_d   = phase_q;
    xa_d      = xa_q;
    ya_d      = ya_q;
    xb_d      = xb_q;
    yb_d      = yb_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    err_d     = err_q;
    stx_neg_d = stx_neg_q;
    sty_neg_d = sty_neg_q;
    // clip the right and lower neighbors at the canvas edge
    wr_en_d   = busy_q && (px < (XW+1)'(CANVAS_WIDTH)) && (py < (YW+1)'(CANVAS_HEIGHT));
    wr_addr_d = AW'(py[YW-1:0]) * AW'(CANVAS_WIDTH) + AW'(px[XW-1:0]);

    if (start_i) begin
      busy_d    = 1'b1;
      phase_d   = PH_CENTER;
      xa_d      = x0_i;
      ya_d      = y0_i;
      xb_d      = x1_i;
      yb_d      = y1_i;
      dx_d      = dx_s;
      dy_d      = dy_s;
      err_d     = dx_s - dy_s;
      stx_neg_d = !(x0_i < x1_i);
      sty_neg_d = !(y0_i < y1_i);
    end else if (busy_q) begin
      if (phase_q != PH_BELOW) begin
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = PH_CENTER;
        if ((xa_q == xb_q) && (ya_q == yb_q)) begin
          busy_d = 1'b0;
        end else begin
          err_d = err_q - ((twice > -dy_q) ? dy_q : '0) + ((twice < dx_q) ? dx_q : '0);
          if (twice > -dy_q) begin
            xa_d = stx_neg_q ? (xa_q - XW'(1)) : (xa_q + XW'(1));
          end
          if (twice < dx_q) begin
            ya_d = sty_neg_q ? (ya_q - YW'(1)) : (ya_q + YW'(1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_CENTER;
      wr_en_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      wr_en_q <= wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q      <= xa_d;
    ya_q      <= ya_d;
    xb_q      <= xb_d;
    yb_q      <= yb_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    err_q     <= err_d;
    stx_neg_q <= stx_neg_d;
    sty_neg_q <= sty_neg_d;
    wr_addr_q <= wr_addr_d;
  end

  assign busy_o    = busy_q;
  assign wr_en_o   = wr_en_q;
  assign wr_addr_o = wr_addr_q;

endmodule

`default_nettype wire

// ----- src/csp_checker.sv -----
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks of the painter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_checker import csp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);

  // one item in flight: the port closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != STAT_READ) |-> out_data_i.pixel_color == '0)
    else $error("pixel color nonzero on a non-read result");

  a_palette_brush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == STAT_PALETTE) |->
      (out_data_i.brush_color == COLOR_BLACK) || (out_data_i.brush_color == COLOR_RED) ||
      (out_data_i.brush_color == COLOR_BLUE) || (out_data_i.brush_color == COLOR_GREEN))
    else $error("palette hit with a brush outside the palette");

endmodule

bind click_stroke_line_painter_core csp_checker u_csp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

`default_nettype wire
